// ----- sv/actr_pkg.sv -----
// Shared types, constants and AES round functions for the CTR keystream unit.
// No dependencies.
package actr_pkg;

  localparam int unsigned NUM_ROUNDS  = 10;
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    REG_KEY_HIGH = 2'd0,
    REG_KEY_LOW  = 2'd1,
    REG_NONCE    = 2'd2,
    REG_IV       = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic        restart;
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [4:0]  valid_bytes;
  } in_word_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
    logic [4:0]  result_valid_bytes;
  } out_word_t;

  // One classified block handed from front to back.
  typedef struct packed {
    logic [127:0] ctr_blk;
    logic [127:0] data;
    logic [4:0]   nbytes;
  } job_t;

  localparam logic [2047:0] SBOX_TBL = {
    128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
    128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
    128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
    128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
    128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
    128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
    128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
    128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
  };

  localparam logic [79:0] RCON_TBL = 80'h01020408102040801b36;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    return SBOX_TBL[(8'd255 - a) * 8 +: 8];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] rnd);
    return RCON_TBL[(4'd10 - rnd) * 8 +: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i sits at bits [127-8i -: 8]
  function automatic logic [127:0] sub_shift(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (r + 4 * c) -: 8] = sbox(s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]);
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] mix_cols(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0]   a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      a0  = s[127 - 32 * c -: 8];
      a1  = s[119 - 32 * c -: 8];
      a2  = s[111 - 32 * c -: 8];
      a3  = s[103 - 32 * c -: 8];
      all = a0 ^ a1 ^ a2 ^ a3;
      t[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
      t[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
      t[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
      t[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
    end
    return t;
  endfunction

  function automatic logic [127:0] key_next(input logic [127:0] k, input logic [3:0] rnd);
    logic [31:0] w3, t, n0, n1, n2, n3;
    w3 = k[31:0];
    t  = {sbox(w3[23:16]), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])}
         ^ {rcon(rnd), 24'h0};
    n0 = k[127:96] ^ t;
    n1 = k[95:64] ^ n0;
    n2 = k[63:32] ^ n1;
    n3 = k[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

endpackage

// ----- sv/actr_fifo.sv -----
// Short job queue between the front and the back of the CTR unit.
// Depends on actr_pkg (job_t).
module actr_fifo #(
  parameter int unsigned DEPTH = actr_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  actr_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output actr_pkg::job_t pop_data
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  actr_pkg::job_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> (!full || pop))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> not_empty)
    else $error("queue pop while empty");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(DEPTH))
    else $error("queue count out of range");
endmodule

// ----- sv/actr_front.sv -----
// Front of the CTR unit: accepts words, tracks the block counter, builds jobs.
// Depends on actr_pkg.
module actr_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  actr_pkg::in_word_t in_word,
  input  logic [31:0]      nonce,
  input  logic [63:0]      iv,
  output logic             push,
  output actr_pkg::job_t   push_data,
  input  logic             q_full
);
  logic [31:0] ctr_r, ctr_nxt, ctr_cur;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;
  assign ctr_cur  = in_word.restart ? 32'd1 : ctr_r;
  assign ctr_nxt  = push ? ctr_cur + 32'd1 : ctr_r;

  always_comb begin
    push_data.ctr_blk = {nonce, iv, ctr_cur};
    push_data.data    = {in_word.data_high, in_word.data_low};
    push_data.nbytes  = (in_word.valid_bytes > 5'd16) ? 5'd16 : in_word.valid_bytes;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ctr_r <= 32'd1;
    else        ctr_r <= ctr_nxt;
  end
endmodule

// ----- sv/actr_back.sv -----
// Back of the CTR unit: pipelined AES-128 rounds with on-the-fly key schedule,
// keystream XOR and byte masking. Depends on actr_pkg.
module actr_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [127:0]       key,
  input  logic               q_not_empty,
  input  actr_pkg::job_t     q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output actr_pkg::out_word_t out_word
);
  localparam int unsigned NR = actr_pkg::NUM_ROUNDS;

  logic [127:0] st_r   [NR];
  logic [127:0] rk_r   [NR];
  logic [127:0] dat_r  [NR];
  logic [4:0]   nb_r   [NR];
  logic [NR-1:0] v_r;
  logic          vo_r;
  actr_pkg::out_word_t res_r, res_nxt;
  logic          en;
  logic [127:0]  rk_last, ks, mask;

  assign en        = !vo_r || out_ready;
  assign q_pop     = q_not_empty && en;
  assign out_valid = vo_r;
  assign out_word  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r  <= '0;
      vo_r <= 1'b0;
    end else if (en) begin
      v_r  <= {v_r[NR-2:0], q_pop};
      vo_r <= v_r[NR-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0]  <= q_data.ctr_blk ^ key;
      rk_r[0]  <= key;
      dat_r[0] <= q_data.data;
      nb_r[0]  <= q_data.nbytes;
    end
  end

  for (genvar g = 1; g < NR; g++) begin : g_round
    logic [127:0] rk_g;
    assign rk_g = actr_pkg::key_next(rk_r[g-1], 4'(g));
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[g]  <= actr_pkg::mix_cols(actr_pkg::sub_shift(st_r[g-1])) ^ rk_g;
        rk_r[g]  <= rk_g;
        dat_r[g] <= dat_r[g-1];
        nb_r[g]  <= nb_r[g-1];
      end
    end
  end

  always_comb begin
    rk_last = actr_pkg::key_next(rk_r[NR-1], 4'(NR));
    ks      = actr_pkg::sub_shift(st_r[NR-1]) ^ rk_last;
    for (int i = 0; i < 16; i++) begin
      mask[127 - 8 * i -: 8] = (5'(i) < nb_r[NR-1]) ? 8'hff : 8'h00;
    end
    {res_nxt.result_high, res_nxt.result_low} = (dat_r[NR-1] ^ ks) & mask;
    res_nxt.result_valid_bytes = nb_r[NR-1];
  end

  always_ff @(posedge clk) begin
    if (en) res_r <= res_nxt;
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
      (vo_r && !out_ready) |=> (vo_r && $stable(res_r)))
    else $error("result lost while stalled");
  a_nbytes: assert property (@(posedge clk) disable iff (!rst_n)
      vo_r |-> (res_r.result_valid_bytes <= 5'd16))
    else $error("valid byte count above 16");
  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
      !en |=> $stable(v_r))
    else $error("pipeline moved while stalled");
endmodule

// ----- sv/aes128_ctr_keystream_xor_unit.sv -----
// AES-128 counter mode (RFC 3686) unit: counter block nonce|IV|counter, keystream XOR.
// One word in and one word out per cycle unless out_ready stalls; words pass through the
// job queue, then the ten fully unrolled, registered round stages that set the rate.
// Depends on actr_pkg, actr_front, actr_fifo, actr_back.
module aes128_ctr_keystream_xor_unit #(
  parameter int unsigned QUEUE_DEPTH = actr_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  actr_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output actr_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  actr_pkg::cfg_reg_t  cfg_index,
  input  logic [63:0]         cfg_data
);
  logic [63:0] key_hi_r, key_lo_r, iv_r;
  logic [31:0] nonce_r;
  logic        push, pop, q_full, q_ne;
  actr_pkg::job_t push_data, pop_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
      nonce_r  <= '0;
      iv_r     <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        actr_pkg::REG_KEY_HIGH: key_hi_r <= cfg_data;
        actr_pkg::REG_KEY_LOW:  key_lo_r <= cfg_data;
        actr_pkg::REG_NONCE:    nonce_r  <= cfg_data[31:0];
        actr_pkg::REG_IV:       iv_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  actr_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_word,
    .nonce(nonce_r), .iv(iv_r), .push, .push_data, .q_full
  );

  actr_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk, .rst_n, .push, .push_data, .full(q_full),
    .pop, .not_empty(q_ne), .pop_data
  );

  actr_back u_back (
    .clk, .rst_n, .key({key_hi_r, key_lo_r}), .q_not_empty(q_ne), .q_data(pop_data),
    .q_pop(pop), .out_valid, .out_ready, .out_word
  );
endmodule
